// File: hdl/dcfp_pkg.sv
// Package: shared types and constants of the delimited command frame parser.
`default_nettype none

package dcfp_pkg;

    // Delimiter characters
    localparam logic [7:0] CH_START   = 8'h3C;  // '<'
    localparam logic [7:0] CH_END     = 8'h3E;  // '>'
    localparam logic [7:0] CH_TO_ID   = 8'h3A;  // ':'
    localparam logic [7:0] CH_TO_DATA = 8'h2F;  // '/'

    // Output field widths
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned CLS_W  = 3;

    // Stream widths: tdata holds index, char and the three lengths, padded to bytes
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned OUT_USER_W = 4;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_CMD  = 2'd1,
        MODE_ID   = 2'd2,
        MODE_DATA = 2'd3
    } mode_t;

    typedef enum logic [CLS_W-1:0] {
        CLS_IGNORE = 3'd0,
        CLS_START  = 3'd1,
        CLS_CMD    = 3'd2,
        CLS_ID     = 3'd3,
        CLS_DATA   = 3'd4,
        CLS_SEP    = 3'd5,
        CLS_END    = 3'd6
    } class_t;

    // One parse result, passed from the parser to the result register
    typedef struct packed {
        class_t            byte_class;
        logic [IDX_W-1:0]  field_index;
        logic [CHAR_W-1:0] char_value;
        logic              field_overflow;
        logic              frame_done;
        logic [LEN_W-1:0]  command_length;
        logic [LEN_W-1:0]  ident_length;
        logic [LEN_W-1:0]  payload_length;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/dcfp_in_stage.sv
// Input register: holds one received byte until the parser consumes it.
`default_nettype none

module dcfp_in_stage (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [dcfp_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic                            load_ok,
    output logic                                 advance,
    output logic [7:0]                           byte_out
);
    import dcfp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Move the held item on whenever the result register can take it
    assign advance  = valid_reg && load_ok;
    assign s_tready = !valid_reg || load_ok;
    assign byte_out = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata[7:0];
        end
    end

endmodule

`default_nettype wire

// File: hdl/dcfp_parse.sv
// Parser: field mode, frame flag, field counters and per-item result logic.
`default_nettype none

module dcfp_parse #(
    parameter int unsigned FIELD_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [7:0]        byte_in,
    output dcfp_pkg::result_t      res
);
    import dcfp_pkg::*;

    localparam int unsigned CNT_W = $clog2(FIELD_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIELD_DEPTH);

    mode_t            mode_reg, mode_next;
    logic             open_reg, open_next;
    logic [CNT_W-1:0] cmd_cnt_reg, cmd_cnt_next;
    logic [CNT_W-1:0] id_cnt_reg, id_cnt_next;
    logic [CNT_W-1:0] data_cnt_reg, data_cnt_next;

    logic [CNT_W-1:0] sel_cnt;
    logic [CNT_W-1:0] sel_cnt_upd;
    logic             sel_full;

    // Pick the counter of the selected field
    always_comb
    begin
        case (mode_reg)
            MODE_CMD:  sel_cnt = cmd_cnt_reg;
            MODE_ID:   sel_cnt = id_cnt_reg;
            MODE_DATA: sel_cnt = data_cnt_reg;
            default:   sel_cnt = '0;
        endcase
        sel_full    = (sel_cnt == DEPTH_C);
        sel_cnt_upd = sel_full ? sel_cnt : sel_cnt + CNT_W'(1);
    end

    // Decode the byte, form the result and the next state
    always_comb
    begin
        mode_next     = mode_reg;
        open_next     = open_reg;
        cmd_cnt_next  = cmd_cnt_reg;
        id_cnt_next   = id_cnt_reg;
        data_cnt_next = data_cnt_reg;
        res           = '0;
        res.byte_class = CLS_IGNORE;

        case (byte_in)
            CH_START:
            begin
                cmd_cnt_next   = '0;
                id_cnt_next    = '0;
                data_cnt_next  = '0;
                open_next      = 1'b1;
                mode_next      = MODE_CMD;
                res.byte_class = CLS_START;
            end
            CH_END:
            begin
                if (open_reg)
                begin
                    res.byte_class     = CLS_END;
                    res.frame_done     = 1'b1;
                    res.command_length = LEN_W'(cmd_cnt_reg);
                    res.ident_length   = LEN_W'(id_cnt_reg);
                    res.payload_length = LEN_W'(data_cnt_reg);
                    cmd_cnt_next       = '0;
                    id_cnt_next        = '0;
                    data_cnt_next      = '0;
                    open_next          = 1'b0;
                    mode_next          = MODE_NONE;
                end
            end
            CH_TO_ID:
            begin
                mode_next      = MODE_ID;
                res.byte_class = CLS_SEP;
            end
            CH_TO_DATA:
            begin
                mode_next      = MODE_DATA;
                res.byte_class = CLS_SEP;
            end
            default:
            begin
                // Store into the selected field, drop when it is full
                if (mode_reg != MODE_NONE)
                begin
                    res.char_value     = byte_in;
                    res.field_overflow = sel_full;
                    res.field_index    = sel_full ? '0 : IDX_W'(sel_cnt);
                    case (mode_reg)
                        MODE_CMD:
                        begin
                            res.byte_class = CLS_CMD;
                            cmd_cnt_next   = sel_cnt_upd;
                        end
                        MODE_ID:
                        begin
                            res.byte_class = CLS_ID;
                            id_cnt_next    = sel_cnt_upd;
                        end
                        default:
                        begin
                            res.byte_class = CLS_DATA;
                            data_cnt_next  = sel_cnt_upd;
                        end
                    endcase
                end
            end
        endcase
    end

    // Update state only when the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NONE;
            open_reg     <= 1'b0;
            cmd_cnt_reg  <= '0;
            id_cnt_reg   <= '0;
            data_cnt_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            open_reg     <= open_next;
            cmd_cnt_reg  <= cmd_cnt_next;
            id_cnt_reg   <= id_cnt_next;
            data_cnt_reg <= data_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_cnt_reg <= DEPTH_C && id_cnt_reg <= DEPTH_C && data_cnt_reg <= DEPTH_C)
        else $error("field counter beyond depth");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && byte_in == CH_START |=>
            open_reg && mode_reg == MODE_CMD && cmd_cnt_reg == '0
            && id_cnt_reg == '0 && data_cnt_reg == '0)
        else $error("start byte did not open a clean frame");

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && byte_in == CH_END && open_reg |=>
            !open_reg && mode_reg == MODE_NONE && cmd_cnt_reg == '0
            && id_cnt_reg == '0 && data_cnt_reg == '0)
        else $error("end byte did not close the frame");
`endif

endmodule

`default_nettype wire

// File: hdl/dcfp_out_stage.sv
// Result register: holds one parse result and drives the master stream.
`default_nettype none

module dcfp_out_stage (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire dcfp_pkg::result_t                res,
    output logic                                  load_ok,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [5:0] field_index, [13:6] char_value, [20:14] command_length,
    // [27:21] ident_length, [34:28] payload_length, [39:35] zero
    output logic [dcfp_pkg::OUT_DATA_W-1:0]       m_tdata,
    // [2:0] byte_class, [3] field_overflow
    output logic [dcfp_pkg::OUT_USER_W-1:0]       m_tuser,
    output logic                                  m_tlast         // frame_done
);
    import dcfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Take a new result when empty or when the current one leaves
    assign load_ok = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ok)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_ok)
        begin
            res_reg <= res;
        end
    end

    // Pack the result onto the stream
    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, res_reg.payload_length, res_reg.ident_length,
                       res_reg.command_length, res_reg.char_value, res_reg.field_index};
    assign m_tuser  = {res_reg.field_overflow, res_reg.byte_class};
    assign m_tlast  = res_reg.frame_done;

endmodule

`default_nettype wire

// File: hdl/delimited_command_frame_parser.sv
// An accepted byte is held in the input register, parsed out of it and captured by the
// result register once it is free. Throughput: one byte per cycle while m_tready is high;
// while a result waits, the input register takes one more.
// Field counters saturate at FIELD_DEPTH; a full field drops the byte and flags it.
// Reset (rst_n low, asynchronous) empties both registers, selects no field,
// closes the frame and clears the three counters.
`default_nettype none

module delimited_command_frame_parser #(
    parameter int unsigned FIELD_DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [dcfp_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [5:0] field_index, [13:6] char_value, [20:14] command_length,
    // [27:21] ident_length, [34:28] payload_length, [39:35] zero
    output logic [dcfp_pkg::OUT_DATA_W-1:0]       m_tdata,
    // [2:0] byte_class, [3] field_overflow
    output logic [dcfp_pkg::OUT_USER_W-1:0]       m_tuser,
    output logic                                  m_tlast    // frame_done
);
    import dcfp_pkg::*;

    logic       load_ok;
    logic       advance;
    logic [7:0] held_byte;
    result_t    res;

    // Hold the incoming byte
    dcfp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .load_ok  (load_ok),
        .advance  (advance),
        .byte_out (held_byte)
    );

    // Classify the byte and advance the parser state
    dcfp_parse #(
        .FIELD_DEPTH (FIELD_DEPTH)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_in (held_byte),
        .res     (res)
    );

    // Register the result toward the master stream
    dcfp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res      (res),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
